// File: rtl/core/keyframe_linear_interpolator_top_assert.svh
// Assertion macros for the keyframe interpolator top level.
// Used by keyframe_linear_interpolator_top.sv; expects clk_i and rst_ni in scope.
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_TOP_ASSERT_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KLI_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define KLI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/kli_pkg.sv
// Shared types and constants for the keyframe linear interpolator.
// No dependencies; imported by every module of the block except kli_ram.
`timescale 1ns / 1ps

package kli_pkg;

  localparam int unsigned KfDepthDefault = 16;
  localparam int unsigned QueueDepth     = 2;
  localparam int unsigned ValW           = 32;
  localparam int unsigned ProdW          = 2 * ValW;
  localparam int unsigned IdxFieldW      = 4;
  localparam int unsigned CountW         = 5;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic StatusOk    = 1'b0;
  localparam logic StatusEmpty = 1'b1;

  typedef struct packed {
    logic [ValW-1:0] time_ms;
    logic [ValW-1:0] x;
    logic [ValW-1:0] y;
  } kli_key_t;

  // One queued transaction. For a query the time field carries the query time.
  typedef struct packed {
    logic                 is_query;
    logic [IdxFieldW-1:0] idx;
    kli_key_t             key;
  } kli_cmd_t;

endpackage

// File: rtl/core/kli_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module kli_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/kli_front.sv
// Input side: takes transactions, drops out-of-range writes, packs the rest.
// Depends on kli_pkg.
`timescale 1ns / 1ps

module kli_front import kli_pkg::*; #(
  parameter int unsigned DEPTH = KfDepthDefault
) (
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 operation_i,
  input  logic [IdxFieldW-1:0] entry_index_i,
  input  logic [ValW-1:0]      key_time_ms_i,
  input  logic [ValW-1:0]      key_x_i,
  input  logic [ValW-1:0]      key_y_i,
  input  logic [ValW-1:0]      query_time_ms_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output kli_cmd_t             push_data_o
);

  logic is_query;
  logic keep;

  assign is_query   = (operation_i == OpQuery);
  // A write to an entry beyond the table is swallowed here.
  assign keep       = is_query || (32'(entry_index_i) < 32'(DEPTH));
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i && keep;

  always_comb begin
    push_data_o.is_query    = is_query;
    push_data_o.idx         = entry_index_i;
    push_data_o.key.time_ms = is_query ? query_time_ms_i : key_time_ms_i;
    push_data_o.key.x       = key_x_i;
    push_data_o.key.y       = key_y_i;
  end

endmodule

// File: rtl/core/kli_queue.sv
// Short register FIFO between the front and back of the interpolator.
// Depends on kli_pkg.
`timescale 1ns / 1ps

module kli_queue import kli_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  kli_cmd_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output kli_cmd_t data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  kli_cmd_t        entry_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/core/kli_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Quotient must fit in ValW bits (high dividend half below the divisor). Depends on kli_pkg.
`timescale 1ns / 1ps

module kli_div import kli_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ProdW-1:0] dividend_i,
  input  logic [ValW-1:0]  divisor_i,
  output logic             done_o,
  output logic [ValW-1:0]  quotient_o
);

  localparam int unsigned StepW = $clog2(ValW);

  logic [ValW-1:0]  rem_q;
  logic [ValW-1:0]  quo_q;
  logic [ValW-1:0]  den_q;
  logic [StepW-1:0] step_q, step_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [ValW:0]    trial;
  logic [ValW:0]    trial_sub;
  logic             fits;

  assign trial     = {rem_q, quo_q[ValW-1]};
  assign trial_sub = trial - {1'b0, den_q};
  assign fits      = (trial >= {1'b0, den_q});

  always_comb begin
    run_d  = run_q;
    step_d = step_q;
    done_d = 1'b0;
    if (start_i) begin
      run_d  = 1'b1;
      step_d = '0;
    end else if (run_q) begin
      step_d = step_q + 1'b1;
      if (step_q == StepW'(ValW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[ProdW-1:ValW];
      quo_q <= dividend_i[ValW-1:0];
      den_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= fits ? trial_sub[ValW-1:0] : trial[ValW-1:0];
      quo_q <= {quo_q[ValW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: rtl/core/kli_back.sv
// Back end: applies table writes, scans keyframes for queries and interpolates.
// Depends on kli_pkg, kli_ram and kli_div.
`timescale 1ns / 1ps

module kli_back import kli_pkg::*; #(
  parameter int unsigned DEPTH = KfDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  kli_cmd_t          cmd_i,
  output logic              cmd_pop_o,
  input  logic [CountW-1:0] count_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ValW-1:0]   x_result_o,
  output logic [ValW-1:0]   y_result_o,
  output logic              status_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;

  logic [CntW-1:0] n_eff;
  logic [CntW-1:0] n_m1;
  logic [IdxW-1:0] last_idx;
  logic            ram_we;
  logic [IdxW-1:0] ram_raddr;
  kli_key_t        cur;

  logic [ValW-1:0] t_q;
  kli_key_t        prev_q;
  logic [ValW-1:0] base_x_q, base_y_q, mag_x_q, mag_y_q;
  logic            neg_x_q, neg_y_q;
  logic [ValW-1:0] num_q, den_q;
  logic [ValW-1:0] res_x_q, res_y_q;
  logic            res_st_q;
  logic [ValW-1:0] out_x_q, out_y_q;
  logic            out_st_q;

  logic [ValW:0]    diff_x, diff_y, ndiff_x, ndiff_y;
  logic [ProdW-1:0] prod_x, prod_y;
  logic             div_start, div_done, div_done_y;
  logic [ValW-1:0]  quo_x, quo_y;

  logic scan_hit;
  logic scan_last;
  logic emit_go;

  // Saturate the programmed count at the table depth.
  always_comb begin
    if (32'(count_i) > 32'(DEPTH)) begin
      n_eff = CntW'(DEPTH);
    end else begin
      n_eff = CntW'(count_i);
    end
  end
  assign n_m1     = n_eff - 1'b1;
  assign last_idx = IdxW'(n_m1);

  assign ram_we    = (state_q == StIdle) && cmd_valid_i && !cmd_i.is_query;
  assign ram_raddr = (state_q == StIdle) ? '0 : idx_q + 1'b1;
  assign cmd_pop_o = (state_q == StIdle) && cmd_valid_i;

  kli_ram #(
    .WIDTH ($bits(kli_key_t)),
    .DEPTH (DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IdxW'(cmd_i.idx)),
    .wdata_i (cmd_i.key),
    .raddr_i (ram_raddr),
    .rdata_o (cur)
  );

  assign scan_hit  = (cur.time_ms >= t_q);
  assign scan_last = (idx_q == last_idx);
  assign emit_go   = !out_valid_q || out_ready_i;

  assign diff_x  = {cur.x[ValW-1], cur.x} - {prev_q.x[ValW-1], prev_q.x};
  assign diff_y  = {cur.y[ValW-1], cur.y} - {prev_q.y[ValW-1], prev_q.y};
  assign ndiff_x = -diff_x;
  assign ndiff_y = -diff_y;

  assign prod_x    = {{ValW{1'b0}}, mag_x_q} * {{ValW{1'b0}}, num_q};
  assign prod_y    = {{ValW{1'b0}}, mag_y_q} * {{ValW{1'b0}}, num_q};
  assign div_start = (state_q == StMul);

  kli_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_x),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quotient_o (quo_x)
  );

  kli_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_y),
    .divisor_i  (den_q),
    .done_o     (div_done_y),
    .quotient_o (quo_y)
  );

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i && cmd_i.is_query) begin
          idx_d   = '0;
          state_d = (n_eff == '0) ? StEmit : StScan;
        end
      end
      StScan: begin
        if (scan_hit) begin
          state_d = (idx_q == '0) ? StEmit : StMul;
        end else if (scan_last) begin
          state_d = StEmit;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StMul: begin
        state_d = StDiv;
      end
      StDiv: begin
        if (div_done && div_done_y) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (emit_go) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && cmd_valid_i && cmd_i.is_query) begin
      t_q      <= cmd_i.key.time_ms;
      res_x_q  <= '0;
      res_y_q  <= '0;
      res_st_q <= StatusEmpty;
    end
    if (state_q == StScan) begin
      prev_q <= cur;
      if (scan_hit || scan_last) begin
        res_x_q  <= cur.x;
        res_y_q  <= cur.y;
        res_st_q <= StatusOk;
      end
      base_x_q <= prev_q.x;
      base_y_q <= prev_q.y;
      neg_x_q  <= diff_x[ValW];
      neg_y_q  <= diff_y[ValW];
      mag_x_q  <= diff_x[ValW] ? ndiff_x[ValW-1:0] : diff_x[ValW-1:0];
      mag_y_q  <= diff_y[ValW] ? ndiff_y[ValW-1:0] : diff_y[ValW-1:0];
      num_q    <= t_q - prev_q.time_ms;
      den_q    <= cur.time_ms - prev_q.time_ms;
    end
    if (state_q == StDiv && div_done) begin
      res_x_q  <= neg_x_q ? base_x_q - quo_x : base_x_q + quo_x;
      res_y_q  <= neg_y_q ? base_y_q - quo_y : base_y_q + quo_y;
      res_st_q <= StatusOk;
    end
    if (state_q == StEmit && emit_go) begin
      out_x_q  <= res_x_q;
      out_y_q  <= res_y_q;
      out_st_q <= res_st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign x_result_o  = out_x_q;
  assign y_result_o  = out_y_q;
  assign status_o    = out_st_q;

endmodule

// File: rtl/core/keyframe_linear_interpolator_top.sv
// Keyframe linear interpolator: keyframe table, search and Q16.16 interpolation.
// A query runs from acceptance to a valid result through a scan of the n valid keyframes
// at one entry per cycle, then, where it must interpolate, a 32-step serial divide.
// Throughput: one query at a time; writes are applied once they reach the idle back end.
// Reset clears the keyframe count, the queue and all control state; table contents stay
// undefined until written. Depends on kli_pkg, kli_front, kli_queue, kli_back.
`timescale 1ns / 1ps

module keyframe_linear_interpolator_top import kli_pkg::*; #(
  parameter int unsigned KEYFRAME_DEPTH = KfDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration: keyframe count register.
  input  logic                 cfg_we_i,
  input  logic [CountW-1:0]    cfg_wdata_i,
  // Input transactions.
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 operation_i,
  input  logic [IdxFieldW-1:0] entry_index_i,
  input  logic [ValW-1:0]      key_time_ms_i,
  input  logic signed [ValW-1:0] key_x_i,
  input  logic signed [ValW-1:0] key_y_i,
  input  logic [ValW-1:0]      query_time_ms_i,
  // Result transactions.
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [ValW-1:0] x_result_o,
  output logic signed [ValW-1:0] y_result_o,
  output logic                 status_o
);

  // The user must write the count register only while the block is idle (the block does
  // not enforce this), so that the back end may read it directly during a query.
  logic [CountW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  logic     q_push;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;
  kli_cmd_t q_wdata;
  kli_cmd_t q_rdata;

  // The front end packs each accepted transaction; writes to entries past the
  // table depth never reach the queue.
  kli_front #(
    .DEPTH (KEYFRAME_DEPTH)
  ) u_front (
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .entry_index_i   (entry_index_i),
    .key_time_ms_i   (key_time_ms_i),
    .key_x_i         (key_x_i),
    .key_y_i         (key_y_i),
    .query_time_ms_i (query_time_ms_i),
    .q_full_i        (q_full),
    .push_o          (q_push),
    .push_data_o     (q_wdata)
  );

  // Writes and queries share one queue so that their order is kept.
  kli_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_rdata)
  );

  logic [ValW-1:0] x_res;
  logic [ValW-1:0] y_res;

  // The back end owns the keyframe RAM, the search sequencer, the two dividers
  // and the output register that decouples it from the result consumer.
  kli_back #(
    .DEPTH (KEYFRAME_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_rdata),
    .cmd_pop_o   (q_pop),
    .count_i     (count_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .x_result_o  (x_res),
    .y_result_o  (y_res),
    .status_o    (status_o)
  );

  assign x_result_o = x_res;
  assign y_result_o = y_res;

`include "keyframe_linear_interpolator_top_assert.svh"

  `KLI_ASSERT_IMPLIES(a_empty_zero, out_valid_o && (status_o == StatusEmpty), (x_result_o == '0) && (y_result_o == '0), "empty-table result carries nonzero values")
  `KLI_ASSERT_IMPLIES(a_pop_valid, q_pop, q_valid, "queue popped while empty")
  `KLI_ASSERT_IMPLIES(a_ready_free, !q_full, in_ready_o, "input stalled with queue space free")
  `KLI_ASSERT_NEXT(a_query_busy, q_pop && q_rdata.is_query, !q_pop, "back end popped while a query is in progress")

endmodule
